>>> rtl/assert_macros.svh
// Assertion macros shared by the block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside reset.
`define SMA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SMA_ASSERT(lbl, clk, rst, prop, msg)
`define SMA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/smasm_pkg.sv
// Package: mesh sizes, fixed-point widths, element matrix, datapath opcodes and control types.
`timescale 1ns / 1ps

package smasm_pkg;

  // Mesh
  localparam int ELEMS_X = 8;
  localparam int ELEMS_Y = 4;
  localparam int NNODES  = (ELEMS_X + 1) * (ELEMS_Y + 1);
  localparam int NDOF    = 2 * NNODES;
  localparam int NDOF_SQ = NDOF * NDOF;

  localparam int NODE_W = $clog2(NNODES);
  localparam int DOF_W  = NODE_W + 1;
  localparam int ADDR_W = $clog2(NDOF_SQ);

  // Input item field widths
  localparam int FUNC_W = 2;
  localparam int ECOL_W = 3;
  localparam int EROW_W = 2;
  localparam int DENS_W = 16;
  localparam int MIDX_W = 7;
  localparam int VAL_W  = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ASSEMBLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

  // Element matrix, 8x8, walked as one 6-bit index (row in the top bits)
  localparam int KE_DIM_W = 3;
  localparam int KE_N     = 64;
  localparam int K_W      = $clog2(KE_N);

  // Arithmetic widths
  localparam int SQ_W       = 17;  // density squared, Q2.15
  localparam int COEFF_W    = 18;  // density cubed, Q3.15
  localparam int KE_W       = 28;  // signed Q0.27 element entry
  localparam int KE_MAG_W   = KE_W - 1;
  localparam int MUL_A_W    = COEFF_W;
  localparam int MUL_B_W    = KE_MAG_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int RND_SHIFT  = 15;
  localparam int RND_W      = PROD_W - RND_SHIFT;
  localparam int ROUND_HALF = 1 << (RND_SHIFT - 1);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Distinct element matrix values in Q0.27, rounded half away from zero
  localparam logic signed [KE_W-1:0] KE_A = 28'sd66371338;   //  0.494505
  localparam logic signed [KE_W-1:0] KE_B = 28'sd23967394;   //  0.178571
  localparam logic signed [KE_W-1:0] KE_C = -28'sd40560329;  // -0.302198
  localparam logic signed [KE_W-1:0] KE_D = -28'sd1843615;   // -0.013736
  localparam logic signed [KE_W-1:0] KE_E = -28'sd33185736;  // -0.247253
  localparam logic signed [KE_W-1:0] KE_F = 28'sd7374593;    //  0.054945

  localparam logic signed [KE_W-1:0] KE_Q27 [KE_N] = '{
    KE_A,  KE_B,  KE_C,  KE_D,  KE_E, -KE_B,  KE_F, -KE_D,
    KE_B,  KE_A, -KE_D,  KE_F, -KE_B,  KE_E,  KE_D,  KE_C,
    KE_C, -KE_D,  KE_A, -KE_B,  KE_F,  KE_D,  KE_E,  KE_B,
    KE_D,  KE_F, -KE_B,  KE_A, -KE_D,  KE_C,  KE_B,  KE_E,
    KE_E, -KE_B,  KE_F, -KE_D,  KE_A,  KE_B,  KE_C,  KE_D,
   -KE_B,  KE_E,  KE_D,  KE_C,  KE_B,  KE_A, -KE_D,  KE_F,
    KE_F,  KE_D,  KE_E,  KE_B,  KE_C, -KE_D,  KE_A, -KE_B,
   -KE_D,  KE_C,  KE_B,  KE_E,  KE_D,  KE_F, -KE_B,  KE_A
  };

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_SQ_MUL,
    OP_SQ_RND,
    OP_CO_MUL,
    OP_CO_RND,
    OP_STREAM,
    OP_RD_ISSUE,
    OP_RD_LOAD,
    OP_CLEAR
  } op_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] cnt;  // element matrix index or clear address
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic              accept;
    logic [FUNC_W-1:0] func;
    logic              elem_bad;
    logic              pipe_busy;
    logic              out_blocked;
  } stat_t;

  // Global degree of freedom of local dof sel, nodes n1 (left) and n2 (right)
  function automatic logic [DOF_W-1:0] edof(input logic [NODE_W-1:0] n1,
                                            input logic [NODE_W-1:0] n2,
                                            input logic [KE_DIM_W-1:0] sel);
    logic [DOF_W-1:0] dof;
    unique case (sel)
      3'd0:    dof = {n1, 1'b0};
      3'd1:    dof = {n1, 1'b1};
      3'd2:    dof = {n2, 1'b0};
      3'd3:    dof = {n2, 1'b1};
      3'd4:    dof = {n2, 1'b0} + DOF_W'(2);
      3'd5:    dof = {n2, 1'b1} + DOF_W'(2);
      3'd6:    dof = {n1, 1'b0} + DOF_W'(2);
      default: dof = {n1, 1'b1} + DOF_W'(2);
    endcase
    return dof;
  endfunction

endpackage

>>> rtl/smasm_if.sv
// Channel interfaces: command items in, read result items out.
`timescale 1ns / 1ps

interface smasm_cmd_if import smasm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ECOL_W-1:0] elem_col;
  logic [EROW_W-1:0] elem_row;
  logic [DENS_W-1:0] density;
  logic [MIDX_W-1:0] mat_row;
  logic [MIDX_W-1:0] mat_col;

  modport source (output valid, func, elem_col, elem_row, density, mat_row, mat_col,
                  input ready);
  modport sink   (input valid, func, elem_col, elem_row, density, mat_row, mat_col,
                  output ready);
endinterface

interface smasm_rsp_if import smasm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] entry_value;
  logic                    saturated;

  modport source (output valid, entry_value, saturated, input ready);
  modport sink   (input valid, entry_value, saturated, output ready);
endinterface

>>> rtl/smasm_sequencer.sv
// Microcode sequencer: program ROM, step counter, loop counter and jump logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smasm_sequencer import smasm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  localparam int UPC_W = 4;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_IF_BAD,
    J_LOOP_K,
    J_LOOP_CLR,
    J_WAIT_DRAIN,
    J_WAIT_OUT
  } jump_t;

  typedef struct packed {
    op_t              op;
    jump_t            jump;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Program entry points
  localparam logic [UPC_W-1:0] UA_FETCH  = 4'd0;
  localparam logic [UPC_W-1:0] UA_ASM    = 4'd1;
  localparam logic [UPC_W-1:0] UA_DRAIN  = 4'd6;
  localparam logic [UPC_W-1:0] UA_RD     = 4'd7;
  localparam logic [UPC_W-1:0] UA_CLR    = 4'd9;
  localparam logic [UPC_W-1:0] UA_LAST   = UA_CLR;

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_FETCH,    J_DISPATCH,   UA_FETCH};
      4'd1:    w = '{OP_SQ_MUL,   J_IF_BAD,     UA_FETCH};
      4'd2:    w = '{OP_SQ_RND,   J_NEXT,       UA_FETCH};
      4'd3:    w = '{OP_CO_MUL,   J_NEXT,       UA_FETCH};
      4'd4:    w = '{OP_CO_RND,   J_NEXT,       UA_FETCH};
      4'd5:    w = '{OP_STREAM,   J_LOOP_K,     UA_DRAIN};
      4'd6:    w = '{OP_NOP,      J_WAIT_DRAIN, UA_FETCH};
      4'd7:    w = '{OP_RD_ISSUE, J_NEXT,       UA_FETCH};
      4'd8:    w = '{OP_RD_LOAD,  J_WAIT_OUT,   UA_FETCH};
      4'd9:    w = '{OP_CLEAR,    J_LOOP_CLR,   UA_FETCH};
      default: w = '{OP_NOP,      J_GOTO,       UA_FETCH};
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0]  upc, upc_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  uword_t            uw;
  logic              stay;
  logic              last_k, last_clr;

  assign uw       = ucode(upc);
  assign last_k   = (cnt[K_W-1:0] == {K_W{1'b1}});
  assign last_clr = (cnt == ADDR_W'(NDOF_SQ - 1));

  always_comb begin
    stay     = 1'b0;
    upc_next = upc + UPC_W'(1);
    unique case (uw.jump)
      J_NEXT:   upc_next = upc + UPC_W'(1);
      J_GOTO:   upc_next = uw.target;
      J_DISPATCH: begin
        if (!stat.accept) begin
          upc_next = upc;
        end else begin
          unique case (stat.func)
            FUNC_ASSEMBLE: upc_next = UA_ASM;
            FUNC_READ:     upc_next = UA_RD;
            FUNC_CLEAR:    upc_next = UA_CLR;
            default:       upc_next = UA_FETCH;
          endcase
        end
      end
      J_IF_BAD:     upc_next = stat.elem_bad ? uw.target : upc + UPC_W'(1);
      J_LOOP_K: begin
        stay     = !last_k;
        upc_next = last_k ? uw.target : upc;
      end
      J_LOOP_CLR: begin
        stay     = !last_clr;
        upc_next = last_clr ? uw.target : upc;
      end
      J_WAIT_DRAIN: upc_next = stat.pipe_busy ? upc : uw.target;
      J_WAIT_OUT:   upc_next = stat.out_blocked ? upc : uw.target;
      default:      upc_next = UA_FETCH;
    endcase
    cnt_next = stay ? cnt + ADDR_W'(1) : '0;
  end

  // Reset starts the clearing sweep of the matrix store
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_CLR;
      cnt <= '0;
    end else begin
      upc <= upc_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    ctrl.op  = uw.op;
    ctrl.cnt = cnt;
  end

  `SMA_ASSERT(a_cnt_in_loop, clk, rst, (cnt != '0) |-> (uw.op == OP_STREAM || uw.op == OP_CLEAR), "loop counter running outside a loop step")
  `SMA_ASSERT(a_upc_range, clk, rst, upc <= UA_LAST, "step counter left the program")

endmodule

>>> rtl/smasm_datapath.sv
// Datapath: input latch, shared multiplier, RMW pipeline, matrix store, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smasm_datapath import smasm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  smasm_cmd_if.sink         cmd,
  smasm_rsp_if.source       rsp,
  input  ctrl_t             ctrl,
  output stat_t             stat
);

  logic accept;

  // Latched item
  logic [ECOL_W-1:0] elem_col_q;
  logic [EROW_W-1:0] elem_row_q;
  logic [DENS_W-1:0] density_q;
  logic [MIDX_W-1:0] mat_row_q, mat_col_q;

  // Density cube
  logic [SQ_W-1:0]    sq;
  logic [COEFF_W-1:0] coeff;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod, rnd_sum;
  logic [RND_W-1:0]   rnd;

  // Stream address and element entry
  logic [NODE_W-1:0]      n1, n2;
  logic [DOF_W-1:0]       dof_i, dof_j;
  logic [ADDR_W-1:0]      st_addr;
  logic signed [KE_W-1:0] ke;

  // RMW pipeline
  logic                    s1_valid, s2_valid, s3_valid;
  logic [ADDR_W-1:0]       s1_addr, s2_addr, s3_addr;
  logic                    s1_neg, s2_neg;
  logic [KE_MAG_W-1:0]     s1_mag;
  logic signed [VAL_W-1:0] s3_add, s3_old;
  logic [VAL_W:0]          sum;
  logic [VAL_W-1:0]        sat_val;
  logic                    sat_hit;
  logic                    sat_flag;

  // Store
  logic [VAL_W-1:0]  mem [NDOF_SQ];
  logic [VAL_W-1:0]  rdata;
  logic              re, we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [VAL_W-1:0]  wdata;

  // Read
  logic              rd_in_range;
  logic [ADDR_W-1:0] rd_addr;

  // Result register
  logic                    out_valid, out_sat, out_blocked, out_load;
  logic signed [VAL_W-1:0] out_value;

  assign cmd.ready = (ctrl.op == OP_FETCH);
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      elem_col_q <= cmd.elem_col;
      elem_row_q <= cmd.elem_row;
      density_q  <= cmd.density;
      mat_row_q  <= cmd.mat_row;
      mat_col_q  <= cmd.mat_col;
    end
  end

  // Shared multiplier: density cube first, then coeff * |KE| per entry
  always_comb begin
    unique case (ctrl.op)
      OP_SQ_MUL: begin
        mul_a = MUL_A_W'(density_q);
        mul_b = MUL_B_W'(density_q);
      end
      OP_CO_MUL: begin
        mul_a = MUL_A_W'(sq);
        mul_b = MUL_B_W'(density_q);
      end
      default: begin
        mul_a = coeff;
        mul_b = s1_mag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign rnd_sum = prod + PROD_W'(ROUND_HALF);
  assign rnd     = rnd_sum[PROD_W-1:RND_SHIFT];

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_SQ_RND) sq <= rnd[SQ_W-1:0];
    if (ctrl.op == OP_CO_RND) coeff <= rnd[COEFF_W-1:0];
  end

  // Entry address: row dof * NDOF + column dof
  assign n1      = NODE_W'(NODE_W'(ELEMS_Y + 1) * NODE_W'(elem_col_q) + NODE_W'(elem_row_q));
  assign n2      = NODE_W'(n1 + NODE_W'(ELEMS_Y + 1));
  assign dof_i   = edof(n1, n2, ctrl.cnt[K_W-1:KE_DIM_W]);
  assign dof_j   = edof(n1, n2, ctrl.cnt[KE_DIM_W-1:0]);
  assign st_addr = ADDR_W'(ADDR_W'(dof_i) * ADDR_W'(NDOF) + ADDR_W'(dof_j));
  assign ke      = KE_Q27[ctrl.cnt[K_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= (ctrl.op == OP_STREAM);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= st_addr;
    s1_neg  <= ke[KE_W-1];
    s1_mag  <= KE_MAG_W'(ke[KE_W-1] ? -ke : ke);
    s2_addr <= s1_addr;
    s2_neg  <= s1_neg;
    s3_addr <= s2_addr;
    s3_add  <= s2_neg ? -VAL_W'(rnd) : VAL_W'(rnd);
    s3_old  <= rdata;
  end

  // Saturating accumulate
  assign sum = {s3_old[VAL_W-1], s3_old} + {s3_add[VAL_W-1], s3_add};

  always_comb begin
    unique case (sum[VAL_W:VAL_W-1])
      2'b01: begin
        sat_val = VAL_MAX;
        sat_hit = 1'b1;
      end
      2'b10: begin
        sat_val = VAL_MIN;
        sat_hit = 1'b1;
      end
      default: begin
        sat_val = sum[VAL_W-1:0];
        sat_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_flag <= 1'b0;
    end else if (ctrl.op == OP_CLEAR) begin
      sat_flag <= 1'b0;
    end else if (s3_valid && sat_hit) begin
      sat_flag <= 1'b1;
    end
  end

  // Read address; out-of-range reads go to entry 0 and return zero
  assign rd_in_range = (32'(mat_row_q) < NDOF) && (32'(mat_col_q) < NDOF);
  assign rd_addr     = rd_in_range ?
                       ADDR_W'(ADDR_W'(mat_row_q) * ADDR_W'(NDOF) + ADDR_W'(mat_col_q)) : '0;

  assign re    = s1_valid || (ctrl.op == OP_RD_ISSUE);
  assign raddr = (ctrl.op == OP_RD_ISSUE) ? rd_addr : s1_addr;
  assign we    = s3_valid || (ctrl.op == OP_CLEAR);
  assign waddr = (ctrl.op == OP_CLEAR) ? ctrl.cnt : s3_addr;
  assign wdata = (ctrl.op == OP_CLEAR) ? '0 : sat_val;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Result register
  assign out_blocked = out_valid && !rsp.ready;
  assign out_load    = (ctrl.op == OP_RD_LOAD) && !out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_value <= rd_in_range ? rdata : '0;
      out_sat   <= sat_flag;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.entry_value = out_value;
  assign rsp.saturated   = out_sat;

  always_comb begin
    stat.accept      = accept;
    stat.func        = cmd.func;
    stat.elem_bad    = (32'(elem_col_q) >= ELEMS_X) || (32'(elem_row_q) >= ELEMS_Y);
    stat.pipe_busy   = s1_valid || s2_valid;
    stat.out_blocked = out_blocked;
  end

  `SMA_ASSERT(a_accept_idle, clk, rst, accept |-> !(s1_valid || s2_valid || s3_valid), "item accepted while the RMW pipeline is busy")
  `SMA_ASSERT(a_clear_excl, clk, rst, (ctrl.op == OP_CLEAR) |-> !s3_valid, "clear sweep collides with an accumulate write")
  `SMA_ASSERT(a_sat_source, clk, rst, $rose(sat_flag) |-> $past(s3_valid), "saturation flag set without an accumulate write")

endmodule

>>> rtl/stiffness_matrix_assembly.sv
// Top level: global stiffness matrix assembler, microcoded sequencer plus datapath.
`timescale 1ns / 1ps

// Usage
//   cmd (sink): valid/ready items carrying func, elem_col, elem_row, density,
//   mat_row and mat_col. func selects assemble element, read entry or clear.
//   rsp (source): one item per read, with entry_value (signed Q4.27) and the
//   sticky saturated flag. Assemble, clear and the unused code give no item.
// Sequence, one item at a time; cmd.ready is high only in the fetch step.
//   Assemble: after the accept, 4 steps for the density cube on the shared
//   multiplier, 64 read-modify-writes at one per cycle on the store's single
//   write port, then a drain step that waits until the pipeline is empty.
//   Element outside the mesh: back to fetch after the first cube step, store untouched.
//   Read: an issue step reads the store, then a load step fills the result register.
//   Clear: one store entry zeroed per cycle, all 8100 entries in turn.
// Reset (synchronous, rst high): runs the same clearing pass over the store
//   before the first item is accepted; saturated flag cleared.
// Back-pressure: a read result waits in the output register; further items
//   are still accepted and worked on, and a second read holds in its last
//   step until the register is free.
module stiffness_matrix_assembly import smasm_pkg::*; (
  input logic         clk,
  input logic         rst,
  smasm_cmd_if.sink   cmd,
  smasm_rsp_if.source rsp
);

  ctrl_t ctrl;
  stat_t stat;

  // Program ROM, step counter and loop counter
  smasm_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Multiplier, accumulate pipeline, 90x90 store and result register
  smasm_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .rsp  (rsp),
    .ctrl (ctrl),
    .stat (stat)
  );

endmodule
